// ===== rtl/core/lhgs_pkg.sv =====
`default_nettype none

package lhgs_pkg;

   localparam int unsigned GAIN_SET_W = 56;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned ACC_W = 30;
   localparam int unsigned PROD_W = 34;
   localparam int unsigned OPND_W = 17;
   localparam int unsigned INTEG_W = 27;
   localparam int unsigned QUOT_W = 11;

   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_UPPER    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_LOWER    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_THR     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_MEASURED  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAINS_OUTSIDE = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAINS_INSIDE  = 3'd5;

   localparam logic signed [ACC_W-1:0] INTEG_LIMIT = 30'sd67107840;
   localparam logic [20:0] POS_SAT = 21'd65535;
   // ceil(2^20 / 25): exact floor(x / 25) for x up to 32768
   localparam logic signed [OPND_W-1:0] RECIP_25 = 17'sd41944;
   localparam int unsigned RECIP_SHIFT = 20;

   localparam int unsigned POS_SHIFT = 4;
   localparam int unsigned SPEED_SHIFT = 3;
   localparam int unsigned CUR_SHIFT = 5;

   typedef enum logic [1:0] {
      ZONE_INIT   = 2'd0,
      ZONE_INSIDE = 2'd1,
      ZONE_ABOVE  = 2'd2,
      ZONE_BELOW  = 2'd3
   } zone_type;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_DECIDE,
      SEQ_MUL_POS,
      SEQ_MUL_SPEED,
      SEQ_MUL_CUR,
      SEQ_MUL_VOLT,
      SEQ_QUOT,
      SEQ_REM,
      SEQ_CLAMP,
      SEQ_DONE
   } seq_type;

   typedef enum logic [1:0] {
      MUL_POS,
      MUL_SPEED,
      MUL_CUR,
      MUL_VOLT
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_POS,
      ACC_ADD_SPEED,
      ACC_ADD_CUR,
      ACC_ADD_VOLT
   } acc_op_type;

   typedef struct packed {
      logic       capture;
      logic       load_gains;
      logic       gain_inside;
      logic       mul_en;
      mul_op_type mul_op;
      acc_op_type acc_op;
      logic       load_quot;
      logic       load_held;
      logic       load_out;
      zone_type   mode;
      logic       reinit;
   } cmd_type;

   typedef struct packed {
      logic dist_ge_upper;
      logic dist_le_lower;
      logic speed_gt_neg_thr;
      logic speed_lt_thr;
      logic out_busy;
   } status_type;

   // round half away from zero on a right shift
   function automatic logic signed [ACC_W-1:0] round_shift(
      input logic signed [PROD_W-1:0] x,
      input int unsigned sh
   );
      logic [PROD_W-1:0] mag;
      logic [PROD_W-1:0] half;
      logic [PROD_W-1:0] q;
      logic signed [ACC_W-1:0] r;
      half = PROD_W'(1) << (sh - 1);
      mag = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
      q = (mag + half) >> sh;
      r = ACC_W'(q);
      return x[PROD_W-1] ? -r : r;
   endfunction

   // floor(r * 1024 / 25) for a remainder below 25
   function automatic logic [9:0] frac_25(input logic [4:0] r);
      logic [9:0] v;
      case (r)
         5'd1:  v = 10'd40;
         5'd2:  v = 10'd81;
         5'd3:  v = 10'd122;
         5'd4:  v = 10'd163;
         5'd5:  v = 10'd204;
         5'd6:  v = 10'd245;
         5'd7:  v = 10'd286;
         5'd8:  v = 10'd327;
         5'd9:  v = 10'd368;
         5'd10: v = 10'd409;
         5'd11: v = 10'd450;
         5'd12: v = 10'd491;
         5'd13: v = 10'd532;
         5'd14: v = 10'd573;
         5'd15: v = 10'd614;
         5'd16: v = 10'd655;
         5'd17: v = 10'd696;
         5'd18: v = 10'd737;
         5'd19: v = 10'd778;
         5'd20: v = 10'd819;
         5'd21: v = 10'd860;
         5'd22: v = 10'd901;
         5'd23: v = 10'd942;
         5'd24: v = 10'd983;
         default: v = 10'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lhgs_req_if.sv =====
`default_nettype none

interface lhgs_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] limp_distance;
   logic signed [15:0] speed;
   logic        [15:0] position;
   logic signed [15:0] measured_current;
   logic signed [15:0] estimated_current;
   logic signed [15:0] drive_voltage;

   modport source (
      output valid, limp_distance, speed, position, measured_current,
             estimated_current, drive_voltage,
      input  ready
   );

   modport sink (
      input  valid, limp_distance, speed, position, measured_current,
             estimated_current, drive_voltage,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/lhgs_rsp_if.sv =====
`default_nettype none

interface lhgs_rsp_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  mode;
   logic               reinit_done;
   logic signed [26:0] integral_start;
   logic        [15:0] active_k1;
   logic signed [15:0] active_k2;
   logic        [15:0] active_k3;
   logic        [7:0]  active_integral_gain;

   modport source (
      output valid, mode, reinit_done, integral_start, active_k1, active_k2,
             active_k3, active_integral_gain,
      input  ready
   );

   modport sink (
      input  valid, mode, reinit_done, integral_start, active_k1, active_k2,
             active_k3, active_integral_gain,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/lhgs_ctrl.sv =====
`default_nettype none

module lhgs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lhgs_pkg::status_type st,
   output lhgs_pkg::cmd_type        cmd
);

   lhgs_pkg::seq_type  seq_ff, seq_in;
   lhgs_pkg::zone_type zone_ff, zone_in;
   logic               reinit_ff, reinit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff    <= lhgs_pkg::SEQ_IDLE;
         zone_ff   <= lhgs_pkg::ZONE_INIT;
         reinit_ff <= 1'b0;
      end else begin
         seq_ff    <= seq_in;
         zone_ff   <= zone_in;
         reinit_ff <= reinit_in;
      end
   end

   always_comb begin
      seq_in    = seq_ff;
      zone_in   = zone_ff;
      reinit_in = reinit_ff;
      req_ready = 1'b0;

      cmd             = '0;
      cmd.mul_op      = lhgs_pkg::MUL_POS;
      cmd.acc_op      = lhgs_pkg::ACC_HOLD;
      cmd.mode        = zone_ff;
      cmd.reinit      = reinit_ff;

      unique case (seq_ff)
         lhgs_pkg::SEQ_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            if (req_valid) begin
               seq_in = lhgs_pkg::SEQ_DECIDE;
            end
         end
         lhgs_pkg::SEQ_DECIDE: begin
            reinit_in = 1'b0;
            unique case (zone_ff)
               lhgs_pkg::ZONE_INIT: begin
                  reinit_in = 1'b1;
                  zone_in   = lhgs_pkg::ZONE_INSIDE;
               end
               lhgs_pkg::ZONE_INSIDE: begin
                  if (st.dist_ge_upper) begin
                     reinit_in = 1'b1;
                     zone_in   = lhgs_pkg::ZONE_ABOVE;
                  end else if (st.dist_le_lower) begin
                     reinit_in = 1'b1;
                     zone_in   = lhgs_pkg::ZONE_BELOW;
                  end
               end
               lhgs_pkg::ZONE_ABOVE: begin
                  if (st.dist_le_lower) begin
                     zone_in = lhgs_pkg::ZONE_BELOW;
                  end else if (!st.dist_ge_upper) begin
                     zone_in         = lhgs_pkg::ZONE_INSIDE;
                     reinit_in       = st.speed_gt_neg_thr;
                     cmd.gain_inside = 1'b1;
                  end
               end
               lhgs_pkg::ZONE_BELOW: begin
                  if (st.dist_ge_upper) begin
                     zone_in = lhgs_pkg::ZONE_ABOVE;
                  end else if (!st.dist_le_lower) begin
                     zone_in         = lhgs_pkg::ZONE_INSIDE;
                     reinit_in       = st.speed_lt_thr;
                     cmd.gain_inside = 1'b1;
                  end
               end
               default: ;
            endcase
            cmd.load_gains = reinit_in;
            seq_in = reinit_in ? lhgs_pkg::SEQ_MUL_POS : lhgs_pkg::SEQ_DONE;
         end
         lhgs_pkg::SEQ_MUL_POS: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = lhgs_pkg::MUL_POS;
            seq_in     = lhgs_pkg::SEQ_MUL_SPEED;
         end
         lhgs_pkg::SEQ_MUL_SPEED: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = lhgs_pkg::MUL_SPEED;
            cmd.acc_op = lhgs_pkg::ACC_LOAD_POS;
            seq_in     = lhgs_pkg::SEQ_MUL_CUR;
         end
         lhgs_pkg::SEQ_MUL_CUR: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = lhgs_pkg::MUL_CUR;
            cmd.acc_op = lhgs_pkg::ACC_ADD_SPEED;
            seq_in     = lhgs_pkg::SEQ_MUL_VOLT;
         end
         lhgs_pkg::SEQ_MUL_VOLT: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = lhgs_pkg::MUL_VOLT;
            cmd.acc_op = lhgs_pkg::ACC_ADD_CUR;
            seq_in     = lhgs_pkg::SEQ_QUOT;
         end
         lhgs_pkg::SEQ_QUOT: begin
            cmd.load_quot = 1'b1;
            seq_in        = lhgs_pkg::SEQ_REM;
         end
         lhgs_pkg::SEQ_REM: begin
            cmd.acc_op = lhgs_pkg::ACC_ADD_VOLT;
            seq_in     = lhgs_pkg::SEQ_CLAMP;
         end
         lhgs_pkg::SEQ_CLAMP: begin
            cmd.load_held = 1'b1;
            seq_in        = lhgs_pkg::SEQ_DONE;
         end
         lhgs_pkg::SEQ_DONE: begin
            if (!st.out_busy) begin
               cmd.load_out = 1'b1;
               seq_in       = lhgs_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = lhgs_pkg::SEQ_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/lhgs_datapath.sv =====
`default_nettype none

module lhgs_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   lhgs_req_if.sink                                    req,
   lhgs_rsp_if.source                                  rsp,
   input  wire logic                                   csr_write_en,
   input  wire logic [lhgs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [lhgs_pkg::GAIN_SET_W-1:0]        csr_wdata,
   input  wire lhgs_pkg::cmd_type                      cmd,
   output lhgs_pkg::status_type                        st
);

   // configuration
   logic [7:0]                        upper_ff;
   logic [7:0]                        lower_ff;
   logic [14:0]                       thr_ff;
   logic                              use_meas_ff;
   logic [lhgs_pkg::GAIN_SET_W-1:0]   gains_out_ff;
   logic [lhgs_pkg::GAIN_SET_W-1:0]   gains_in_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff     <= '0;
         lower_ff     <= '0;
         thr_ff       <= '0;
         use_meas_ff  <= 1'b0;
         gains_out_ff <= '0;
         gains_in_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lhgs_pkg::CSR_ZONE_UPPER:    upper_ff     <= csr_wdata[7:0];
            lhgs_pkg::CSR_ZONE_LOWER:    lower_ff     <= csr_wdata[7:0];
            lhgs_pkg::CSR_SPEED_THR:     thr_ff       <= csr_wdata[14:0];
            lhgs_pkg::CSR_USE_MEASURED:  use_meas_ff  <= csr_wdata[0];
            lhgs_pkg::CSR_GAINS_OUTSIDE: gains_out_ff <= csr_wdata;
            lhgs_pkg::CSR_GAINS_INSIDE:  gains_in_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured input word
   logic signed [15:0] dist_ff;
   logic signed [15:0] speed_ff;
   logic        [15:0] pos_ff;
   logic signed [15:0] meas_ff;
   logic signed [15:0] est_ff;
   logic signed [15:0] volt_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dist_ff  <= req.limp_distance;
         speed_ff <= req.speed;
         pos_ff   <= req.position;
         meas_ff  <= req.measured_current;
         est_ff   <= req.estimated_current;
         volt_ff  <= req.drive_voltage;
      end
   end

   // zone compares
   logic signed [16:0] dist_x;
   logic signed [16:0] speed_x;
   logic signed [16:0] upper_x;
   logic signed [16:0] lower_x;
   logic signed [16:0] thr_x;

   assign dist_x  = {dist_ff[15], dist_ff};
   assign speed_x = {speed_ff[15], speed_ff};
   assign upper_x = $signed({9'd0, upper_ff});
   assign lower_x = $signed({9'd0, lower_ff}) - 17'sd255;
   assign thr_x   = $signed({2'd0, thr_ff});

   // active gains and held integral start
   logic        [15:0]                    k1_ff;
   logic signed [15:0]                    k2_ff;
   logic        [15:0]                    k3_ff;
   logic        [7:0]                     ki_ff;
   logic signed [lhgs_pkg::INTEG_W-1:0]   held_ff;
   logic        [lhgs_pkg::GAIN_SET_W-1:0] gain_set;

   assign gain_set = cmd.gain_inside ? gains_in_ff : gains_out_ff;

   // shared multiplier
   logic        [20:0]                  pos_x25;
   logic        [15:0]                  pos_sat;
   logic        [16:0]                  volt_mag;
   logic signed [15:0]                  cur;
   logic signed [lhgs_pkg::OPND_W-1:0]  mul_a;
   logic signed [lhgs_pkg::OPND_W-1:0]  mul_b;
   logic signed [lhgs_pkg::PROD_W-1:0]  product_ff;

   assign pos_x25  = 21'(pos_ff) * 21'd25;
   assign pos_sat  = (pos_x25 > lhgs_pkg::POS_SAT) ? 16'hFFFF : pos_x25[15:0];
   assign volt_mag = volt_ff[15] ? 17'(-$signed({volt_ff[15], volt_ff})) : {1'b0, volt_ff};
   assign cur      = use_meas_ff ? meas_ff : est_ff;

   always_comb begin
      unique case (cmd.mul_op)
         lhgs_pkg::MUL_POS: begin
            mul_a = $signed({1'b0, pos_sat});
            mul_b = $signed({1'b0, k1_ff});
         end
         lhgs_pkg::MUL_SPEED: begin
            mul_a = speed_x;
            mul_b = {k2_ff[15], k2_ff};
         end
         lhgs_pkg::MUL_CUR: begin
            mul_a = {cur[15], cur};
            mul_b = $signed({1'b0, k3_ff});
         end
         lhgs_pkg::MUL_VOLT: begin
            mul_a = $signed(volt_mag);
            mul_b = lhgs_pkg::RECIP_25;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // voltage term: |v|*1024/25 as quotient*1024 + table(remainder)
   logic [lhgs_pkg::QUOT_W-1:0]       quot_ff;
   logic [16:0]                       quot_x25;
   logic [16:0]                       rem_full;
   logic [20:0]                       volt_term_mag;
   logic signed [lhgs_pkg::ACC_W-1:0] volt_term_abs;
   logic signed [lhgs_pkg::ACC_W-1:0] volt_term;

   assign quot_x25      = 17'(quot_ff) * 17'd25;
   assign rem_full      = volt_mag - quot_x25;
   assign volt_term_mag = {quot_ff, 10'd0} + 21'(lhgs_pkg::frac_25(rem_full[4:0]));
   assign volt_term_abs = $signed(30'(volt_term_mag));
   assign volt_term     = volt_ff[15] ? -volt_term_abs : volt_term_abs;

   logic signed [lhgs_pkg::ACC_W-1:0] acc_ff;
   logic signed [lhgs_pkg::ACC_W-1:0] clamped;

   always_comb begin
      if (acc_ff > lhgs_pkg::INTEG_LIMIT) begin
         clamped = lhgs_pkg::INTEG_LIMIT;
      end else if (acc_ff < -lhgs_pkg::INTEG_LIMIT) begin
         clamped = -lhgs_pkg::INTEG_LIMIT;
      end else begin
         clamped = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         product_ff <= mul_a * mul_b;
      end
      if (cmd.load_quot) begin
         quot_ff <= product_ff[lhgs_pkg::RECIP_SHIFT +: lhgs_pkg::QUOT_W];
      end
      case (cmd.acc_op)
         lhgs_pkg::ACC_LOAD_POS:
            acc_ff <= lhgs_pkg::round_shift(product_ff, lhgs_pkg::POS_SHIFT);
         lhgs_pkg::ACC_ADD_SPEED:
            acc_ff <= acc_ff + lhgs_pkg::round_shift(product_ff, lhgs_pkg::SPEED_SHIFT);
         lhgs_pkg::ACC_ADD_CUR:
            acc_ff <= acc_ff + lhgs_pkg::round_shift(product_ff, lhgs_pkg::CUR_SHIFT);
         lhgs_pkg::ACC_ADD_VOLT:
            acc_ff <= acc_ff + volt_term;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff   <= '0;
         k2_ff   <= '0;
         k3_ff   <= '0;
         ki_ff   <= '0;
         held_ff <= '0;
      end else begin
         if (cmd.load_gains) begin
            k1_ff <= gain_set[15:0];
            k2_ff <= $signed(gain_set[31:16]);
            k3_ff <= gain_set[47:32];
            ki_ff <= gain_set[55:48];
         end
         if (cmd.load_held) begin
            held_ff <= lhgs_pkg::INTEG_W'(clamped);
         end
      end
   end

   // output register
   logic                                rsp_valid_ff;
   logic        [1:0]                   mode_ff;
   logic                                reinit_ff;
   logic signed [lhgs_pkg::INTEG_W-1:0] integ_ff;
   logic        [15:0]                  out_k1_ff;
   logic signed [15:0]                  out_k2_ff;
   logic        [15:0]                  out_k3_ff;
   logic        [7:0]                   out_ki_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mode_ff   <= cmd.mode;
         reinit_ff <= cmd.reinit;
         integ_ff  <= held_ff;
         out_k1_ff <= k1_ff;
         out_k2_ff <= k2_ff;
         out_k3_ff <= k3_ff;
         out_ki_ff <= ki_ff;
      end
   end

   assign rsp.valid                = rsp_valid_ff;
   assign rsp.mode                 = mode_ff;
   assign rsp.reinit_done          = reinit_ff;
   assign rsp.integral_start       = integ_ff;
   assign rsp.active_k1            = out_k1_ff;
   assign rsp.active_k2            = out_k2_ff;
   assign rsp.active_k3            = out_k3_ff;
   assign rsp.active_integral_gain = out_ki_ff;

   assign st.dist_ge_upper    = dist_x >= upper_x;
   assign st.dist_le_lower    = dist_x <= lower_x;
   assign st.speed_gt_neg_thr = speed_x > -thr_x;
   assign st.speed_lt_thr     = speed_x < thr_x;
   assign st.out_busy         = rsp_valid_ff && !rsp.ready;

endmodule

`default_nettype wire

// ===== rtl/core/limp_home_gain_scheduler.sv =====
// An accepted word is captured and its zone decided; on a gain switch the single 17x17
//   multiplier steps through four products, then the /25 step and the clamp follow, else
//   the word goes straight to done. A new word is taken only once the last is done.
// A finished word waits in the output register while the next one is taken.
// Reset (synchronous, active high): init zone, zero gains, zero integral start,
//   all configuration registers cleared.
`default_nettype none

module limp_home_gain_scheduler (
   input  wire logic                             clock,
   input  wire logic                             reset,
   lhgs_req_if.sink                              req,
   lhgs_rsp_if.source                            rsp,
   input  wire logic                             csr_write_en,
   input  wire logic [lhgs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lhgs_pkg::GAIN_SET_W-1:0]  csr_wdata
);

   lhgs_pkg::cmd_type    cmd;
   lhgs_pkg::status_type st;

   lhgs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .st        (st),
      .cmd       (cmd)
   );

   lhgs_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .st           (st)
   );

   a_integ_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.integral_start <= 27'sd67107840) &&
                    (rsp.integral_start >= -27'sd67107840))
      else $error("integral start out of clamp range");

   a_mode_not_init: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.mode != lhgs_pkg::ZONE_INIT))
      else $error("result word reports init zone");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("second word taken while one is in work");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |-> !cmd.load_out)
      else $error("output register overwritten before taken");

endmodule

`default_nettype wire
